// ===== design/lsnt_pkg.sv =====
// ----------------------------------------------------------------------------
// lsnt_pkg: shared types and constants for the sector nearest target block
// Register indexes, widths, reset values, controller commands and status.
// ----------------------------------------------------------------------------
package lsnt_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int IDX_W       = $clog2(MAX_SAMPLES) + 1;
	localparam int ANGLE_W     = 32;
	localparam int RANGE_W     = 16;
	localparam int HITS_W      = 13;
	localparam int MEAN_W      = 19;
	localparam int CFG_W       = 20;
	localparam int CFG_IDX_W   = 3;
	localparam int QUO_W       = ANGLE_W - 1;
	localparam int DIV_STEPS   = QUO_W;
	localparam int DCNT_W      = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEIL  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_HITS    = 3'd5;

	localparam logic signed [19:0] ANGLE_START_RST = -20'sd205887;
	localparam logic signed [16:0] ANGLE_STEP_RST  = 17'sd573;
	localparam logic [17:0]        HALF_WIDTH_RST  = 18'd34275;
	localparam logic [15:0]        RANGE_FLOOR_RST = 16'd200;
	localparam logic [15:0]        RANGE_CEIL_RST  = 16'd3000;
	localparam logic [12:0]        MIN_HITS_RST    = 13'd5;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	typedef struct packed {
		logic sample_en;
		logic div_load;
		logic div_step;
		logic out_load;
		logic scan_clear;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} sts_t;

endpackage

// ===== design/lsnt_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsnt_ctrl: sequencer for sample intake, scan-end division and result
// Takes samples while idle, runs the divider after a scan end, then hands
// the result to the output register once it is free.
// ----------------------------------------------------------------------------
module lsnt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            scan_end,
	input  logic            out_ready,
	input  lsnt_pkg::sts_t  sts,
	output logic            in_ready,
	output logic            out_valid,
	output lsnt_pkg::cmd_t  cmd
);

	lsnt_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == lsnt_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		case (state_q)
			lsnt_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.sample_en = 1'b1;
					if (scan_end) begin
						state_d = lsnt_pkg::ST_LOAD;
					end
				end
			end
			lsnt_pkg::ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = lsnt_pkg::ST_DIV;
			end
			lsnt_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = lsnt_pkg::ST_DONE;
				end
			end
			lsnt_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.out_load   = 1'b1;
					cmd.scan_clear = 1'b1;
					state_d        = lsnt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lsnt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lsnt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/lsnt_dpath.sv =====
// ----------------------------------------------------------------------------
// lsnt_dpath: configuration, scan accumulators, divider and result register
// Per-sample window test and accumulate; restoring divider, one quotient
// bit per cycle, for the mean angle.
// ----------------------------------------------------------------------------
module lsnt_dpath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [lsnt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lsnt_pkg::CFG_W-1:0]             cfg_wdata,
	input  logic [lsnt_pkg::RANGE_W-1:0]           range_mm,
	input  logic                                   range_finite,
	input  lsnt_pkg::cmd_t                         cmd,
	output lsnt_pkg::sts_t                         sts,
	output logic                                   detected,
	output logic [lsnt_pkg::RANGE_W-1:0]           nearest_mm,
	output logic signed [lsnt_pkg::MEAN_W-1:0]     mean_angle
);

	// configuration
	logic signed [19:0] angle_start_q;
	logic signed [16:0] angle_step_q;
	logic [17:0]        half_width_q;
	logic [15:0]        range_floor_q;
	logic [15:0]        range_ceil_q;
	logic [12:0]        min_hits_q;

	// scan state
	logic signed [lsnt_pkg::ANGLE_W-1:0] cur_angle_q;
	logic [lsnt_pkg::IDX_W-1:0]          idx_q;
	logic [lsnt_pkg::RANGE_W-1:0]        nearest_q;
	logic signed [lsnt_pkg::ANGLE_W-1:0] angle_sum_q;
	logic [lsnt_pkg::HITS_W-1:0]         hits_q;

	// divider
	logic [lsnt_pkg::HITS_W-1:0]  rem_q;
	logic [lsnt_pkg::QUO_W-1:0]   quo_q;
	logic                         neg_q;
	logic [lsnt_pkg::DCNT_W-1:0]  dcnt_q;

	// result
	logic                                 detected_q;
	logic [lsnt_pkg::RANGE_W-1:0]         nearest_out_q;
	logic signed [lsnt_pkg::MEAN_W-1:0]   mean_q;

	logic signed [lsnt_pkg::ANGLE_W-1:0] angle;
	logic signed [lsnt_pkg::ANGLE_W-1:0] hw_s;
	logic signed [lsnt_pkg::ANGLE_W-1:0] sum_abs;
	logic                                in_scan;
	logic                                hit;
	logic [lsnt_pkg::HITS_W:0]           rem_sh;
	logic [lsnt_pkg::HITS_W+1:0]         diff;
	logic [lsnt_pkg::HITS_W-1:0]         need;
	logic                                det;
	logic [lsnt_pkg::MEAN_W-1:0]         quo_lo;
	logic [lsnt_pkg::MEAN_W-1:0]         mean_mag;

	// first sample of a scan takes its angle straight from angle_start
	assign angle   = (idx_q == '0) ? {{(lsnt_pkg::ANGLE_W-20){angle_start_q[19]}}, angle_start_q}
	                               : cur_angle_q;
	assign hw_s    = {{(lsnt_pkg::ANGLE_W-18){1'b0}}, half_width_q};
	assign in_scan = (idx_q < lsnt_pkg::IDX_W'(lsnt_pkg::MAX_SAMPLES));
	assign hit     = range_finite && (range_mm >= range_floor_q) && (range_mm <= range_ceil_q)
	                 && (angle >= -hw_s) && (angle <= hw_s) && in_scan;

	assign sum_abs = angle_sum_q[lsnt_pkg::ANGLE_W-1] ? -angle_sum_q : angle_sum_q;
	assign rem_sh  = {rem_q, quo_q[lsnt_pkg::QUO_W-1]};
	assign diff    = {1'b0, rem_sh} - {2'b00, hits_q};

	assign need     = (min_hits_q == '0) ? lsnt_pkg::HITS_W'(1) : min_hits_q;
	assign det      = (hits_q >= need);
	assign quo_lo   = quo_q[lsnt_pkg::MEAN_W-1:0];
	assign mean_mag = neg_q ? -quo_lo : quo_lo;

	assign sts.div_last = (dcnt_q == lsnt_pkg::DCNT_W'(lsnt_pkg::DIV_STEPS - 1));

	assign detected   = detected_q;
	assign nearest_mm = nearest_out_q;
	assign mean_angle = mean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= lsnt_pkg::ANGLE_START_RST;
			angle_step_q  <= lsnt_pkg::ANGLE_STEP_RST;
			half_width_q  <= lsnt_pkg::HALF_WIDTH_RST;
			range_floor_q <= lsnt_pkg::RANGE_FLOOR_RST;
			range_ceil_q  <= lsnt_pkg::RANGE_CEIL_RST;
			min_hits_q    <= lsnt_pkg::MIN_HITS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lsnt_pkg::REG_ANGLE_START: angle_start_q <= cfg_wdata[19:0];
				lsnt_pkg::REG_ANGLE_STEP:  angle_step_q  <= cfg_wdata[16:0];
				lsnt_pkg::REG_HALF_WIDTH:  half_width_q  <= cfg_wdata[17:0];
				lsnt_pkg::REG_RANGE_FLOOR: range_floor_q <= cfg_wdata[15:0];
				lsnt_pkg::REG_RANGE_CEIL:  range_ceil_q  <= cfg_wdata[15:0];
				lsnt_pkg::REG_MIN_HITS:    min_hits_q    <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			nearest_q   <= '1;
			angle_sum_q <= '0;
			hits_q      <= '0;
		end else if (cmd.scan_clear) begin
			idx_q       <= '0;
			nearest_q   <= '1;
			angle_sum_q <= '0;
			hits_q      <= '0;
		end else if (cmd.sample_en && in_scan) begin
			idx_q <= idx_q + 1'b1;
			if (hit) begin
				if (range_mm < nearest_q) begin
					nearest_q <= range_mm;
				end
				angle_sum_q <= angle_sum_q + angle;
				hits_q      <= hits_q + 1'b1;
			end
		end
	end

	// current angle is only read once idx is nonzero
	always_ff @(posedge clk) begin
		if (cmd.sample_en && in_scan) begin
			cur_angle_q <= angle + {{(lsnt_pkg::ANGLE_W-17){angle_step_q[16]}}, angle_step_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_load) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= '0;
			quo_q <= sum_abs[lsnt_pkg::QUO_W-1:0];
			neg_q <= angle_sum_q[lsnt_pkg::ANGLE_W-1];
		end else if (cmd.div_step) begin
			rem_q <= diff[lsnt_pkg::HITS_W+1] ? rem_sh[lsnt_pkg::HITS_W-1:0]
			                                  : diff[lsnt_pkg::HITS_W-1:0];
			quo_q <= {quo_q[lsnt_pkg::QUO_W-2:0], ~diff[lsnt_pkg::HITS_W+1]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			detected_q    <= det;
			nearest_out_q <= det ? nearest_q : '0;
			mean_q        <= det ? mean_mag : '0;
		end
	end

endmodule

// ===== design/lidar_sector_nearest_target.sv =====
// ----------------------------------------------------------------------------
// lidar_sector_nearest_target: nearest in-window return in the front sector
// Throughput: one sample per cycle while idle; a scan-end transfer blocks input through setup,
// the 31-step divider and handoff, longer while a prior result waits.
// Reset: configuration to defaults, scan state cleared, no result pending.
// ----------------------------------------------------------------------------
module lidar_sector_nearest_target (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [lsnt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lsnt_pkg::CFG_W-1:0]             cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [lsnt_pkg::RANGE_W-1:0]           range_mm,
	input  logic                                   range_finite,
	input  logic                                   scan_end,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   detected,
	output logic [lsnt_pkg::RANGE_W-1:0]           nearest_mm,
	output logic signed [lsnt_pkg::MEAN_W-1:0]     mean_angle
);

	lsnt_pkg::cmd_t cmd;
	lsnt_pkg::sts_t sts;

	lsnt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.scan_end  (scan_end),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	lsnt_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.range_mm     (range_mm),
		.range_finite (range_finite),
		.cmd          (cmd),
		.sts          (sts),
		.detected     (detected),
		.nearest_mm   (nearest_mm),
		.mean_angle   (mean_angle)
	);

`ifndef SYNTHESIS
	a_end_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && scan_end |=> !in_ready)
		else $error("input not blocked after scan end transfer");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !detected |-> (nearest_mm == '0) && (mean_angle == '0))
		else $error("non-detection result carries nonzero payload");

	a_div_excl_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.div_load) |-> !cmd.sample_en && !in_ready)
		else $error("sample taken while divider busy");
`endif

endmodule

// ===== sim/tb_lidar_sector_nearest_target.sv =====
// ----------------------------------------------------------------------------
// tb_lidar_sector_nearest_target: self-checking bench for the sector finder
// Feeds lidar scans through the valid/ready sample channel with random gaps,
// predicts each scan report in-bench, and checks every report transfer.
// ----------------------------------------------------------------------------
module tb_lidar_sector_nearest_target;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  DRAIN_CYCLES  = 48;
	localparam int  CYCLE_LIMIT   = 1500000;
	localparam int  RANDOM_PHASES = 6;
	localparam int  PHASE_ITEMS   = 150;
	localparam logic [lsnt_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [lsnt_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [lsnt_pkg::RANGE_W-1:0] dist_mm;
		logic                         finite;
		logic                         last;
	} sample_t;

	typedef struct packed {
		logic                               detected;
		logic [lsnt_pkg::RANGE_W-1:0]       nearest;
		logic signed [lsnt_pkg::MEAN_W-1:0] mean;
	} scan_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [lsnt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lsnt_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [lsnt_pkg::RANGE_W-1:0] range_mm = '0;
	logic range_finite = 1'b0;
	logic scan_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic detected;
	logic [lsnt_pkg::RANGE_W-1:0] nearest_mm;
	logic signed [lsnt_pkg::MEAN_W-1:0] mean_angle;

	lidar_sector_nearest_target dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.range_mm     (range_mm),
		.range_finite (range_finite),
		.scan_end     (scan_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.detected     (detected),
		.nearest_mm   (nearest_mm),
		.mean_angle   (mean_angle)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// register mirror
	logic signed [19:0] cfg_start     = lsnt_pkg::ANGLE_START_RST;
	logic signed [16:0] cfg_step      = lsnt_pkg::ANGLE_STEP_RST;
	logic [17:0]        cfg_halfw     = lsnt_pkg::HALF_WIDTH_RST;
	logic [15:0]        cfg_floor     = lsnt_pkg::RANGE_FLOOR_RST;
	logic [15:0]        cfg_ceil      = lsnt_pkg::RANGE_CEIL_RST;
	logic [12:0]        cfg_min_hits  = lsnt_pkg::MIN_HITS_RST;

	// scan accumulator mirror
	longint                       scan_angle = 0;
	int                           scan_index = 0;
	logic [lsnt_pkg::RANGE_W-1:0] scan_nearest = '1;
	longint                       scan_angle_sum = 0;
	int                           scan_hits = 0;

	sample_t      sample_queue[$];
	scan_report_t pending_reports[$];
	int           mismatch_count = 0;
	int           cycle_count = 0;
	bit           steady = 1'b0;

	function automatic void track_sample(sample_t s);
		longint angle;
		longint hw;
		longint mean;
		int need;
		scan_report_t rep;
		if (scan_index < lsnt_pkg::MAX_SAMPLES) begin
			angle = (scan_index == 0) ? longint'(cfg_start) : scan_angle;
			hw = longint'(cfg_halfw);
			if (s.finite && s.dist_mm >= cfg_floor && s.dist_mm <= cfg_ceil &&
			    angle >= -hw && angle <= hw) begin
				if (s.dist_mm < scan_nearest)
					scan_nearest = s.dist_mm;
				scan_angle_sum += angle;
				scan_hits++;
			end
			scan_angle = angle + longint'(cfg_step);
			scan_index++;
		end
		if (s.last) begin
			need = (cfg_min_hits == 0) ? 1 : int'(cfg_min_hits);
			if (scan_hits >= need && scan_hits > 0) begin
				mean = scan_angle_sum / longint'(scan_hits);
				rep.detected = 1'b1;
				rep.nearest = scan_nearest;
				rep.mean = mean[lsnt_pkg::MEAN_W-1:0];
			end else begin
				rep = '0;
			end
			pending_reports.insert(pending_reports.size(), rep);
			scan_angle = longint'(cfg_start);
			scan_index = 0;
			scan_nearest = '1;
			scan_angle_sum = 0;
			scan_hits = 0;
		end
	endfunction

	// sample driver
	sample_t on_wire;
	int send_wait = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			range_mm <= '0;
			range_finite <= 1'b0;
			scan_end <= 1'b0;
			send_wait = 0;
		end else begin
			if (in_valid && in_ready)
				track_sample(on_wire);
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (sample_queue.size() != 0) begin
					on_wire = sample_queue.pop_front();
					range_mm <= on_wire.dist_mm;
					range_finite <= on_wire.finite;
					scan_end <= on_wire.last;
					in_valid <= 1'b1;
					send_wait = steady ? 0 : $urandom_range(0, 7);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_field(input string name, input logic signed [63:0] expv,
	                            input logic signed [63:0] actv);
		if (expv !== actv) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, expv, actv);
			mismatch_count++;
		end
	endtask

	// report monitor
	int recv_wait = 0;
	scan_report_t due;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_reports.size() == 0) begin
					$display("%0t unexpected report: detected %0d nearest %0d mean %0d",
					         $time, detected, nearest_mm, mean_angle);
					mismatch_count++;
				end else begin
					due = pending_reports.pop_front();
					report_field("detected", {63'd0, due.detected}, {63'd0, detected});
					report_field("nearest_mm", {48'd0, due.nearest}, {48'd0, nearest_mm});
					report_field("mean_angle", 64'(due.mean), 64'(mean_angle));
				end
				recv_wait = steady ? 0 : $urandom_range(0, 7);
			end else if (out_valid && recv_wait > 0) begin
				recv_wait--;
			end
			out_ready <= (recv_wait == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[lidar_sector_nearest_target] ERROR");
			$finish;
		end
	end

	function automatic logic [lsnt_pkg::CFG_W-1:0] pad(input longint value, input int width,
	                                                   input bit dirty);
		logic [lsnt_pkg::CFG_W-1:0] v;
		logic [lsnt_pkg::CFG_W-1:0] mask;
		v = value[lsnt_pkg::CFG_W-1:0];
		if (width < lsnt_pkg::CFG_W) begin
			mask = (20'd1 << width) - 20'd1;
			v = v & mask;
			if (dirty)
				v = v | (20'($urandom()) & ~mask);
		end
		return v;
	endfunction

	task automatic write_reg(input logic [lsnt_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [lsnt_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			lsnt_pkg::REG_ANGLE_START: cfg_start = data[19:0];
			lsnt_pkg::REG_ANGLE_STEP:  cfg_step = data[16:0];
			lsnt_pkg::REG_HALF_WIDTH:  cfg_halfw = data[17:0];
			lsnt_pkg::REG_RANGE_FLOOR: cfg_floor = data[15:0];
			lsnt_pkg::REG_RANGE_CEIL:  cfg_ceil = data[15:0];
			lsnt_pkg::REG_MIN_HITS:    cfg_min_hits = data[12:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input longint start, input longint step, input longint hw,
	                          input longint lo, input longint hi, input longint need,
	                          input bit dirty);
		write_reg(lsnt_pkg::REG_ANGLE_START, pad(start, 20, dirty));
		write_reg(lsnt_pkg::REG_ANGLE_STEP, pad(step, 17, dirty));
		write_reg(lsnt_pkg::REG_HALF_WIDTH, pad(hw, 18, dirty));
		write_reg(lsnt_pkg::REG_RANGE_FLOOR, pad(lo, 16, dirty));
		write_reg(lsnt_pkg::REG_RANGE_CEIL, pad(hi, 16, dirty));
		write_reg(lsnt_pkg::REG_MIN_HITS, pad(need, 13, dirty));
	endtask

	task automatic push_sample(input logic [lsnt_pkg::RANGE_W-1:0] r, input logic fin,
	                           input logic last);
		sample_t s;
		s.dist_mm = r;
		s.finite = fin;
		s.last = last;
		sample_queue.insert(sample_queue.size(), s);
	endtask

	// wait until every sample is taken and every report is back, then let the block drain
	task automatic settle();
		while (sample_queue.size() != 0 || in_valid || pending_reports.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		longint start, step, hw, lo, hi, need;
		int len, items;
		logic [lsnt_pkg::RANGE_W-1:0] r;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// defaults: sector is crossed around sample 300..419
		for (int i = 0; i < 420; i++)
			push_sample(16'($urandom_range(150, 3100)), $urandom_range(0, 19) != 0,
			            i == 419);
		settle();

		// window edges, non-finite sample, single angle sector
		set_config(0, 0, 0, 100, 200, 1, 1'b0);
		push_sample(100, 1, 0);
		push_sample(200, 1, 0);
		push_sample(99, 1, 0);
		push_sample(201, 1, 0);
		push_sample(150, 0, 0);
		push_sample(0, 1, 1);
		push_sample(16'hFFFF, 1, 1);
		settle();
		set_config(0, 0, 0, 0, 65535, 1, 1'b0);
		push_sample(16'hFFFF, 1, 1);
		push_sample(0, 1, 1);
		settle();

		// empty window
		set_config(0, 0, 0, 500, 499, 1, 1'b0);
		push_sample(499, 1, 0);
		push_sample(500, 1, 1);
		settle();

		// zero min_hits acts as one
		set_config(0, 0, 0, 0, 65535, 0, 1'b0);
		push_sample(300, 0, 1);
		push_sample(300, 1, 1);
		settle();

		// sector edges, widest sector
		set_config(-205887, 205887, 205887, 0, 65535, 3, 1'b0);
		for (int i = 0; i < 4; i++)
			push_sample(16'(1000 - i), 1, i == 3);
		settle();

		// extreme start and most negative step
		set_config(411775, -65536, 100000, 0, 65535, 1, 1'b0);
		for (int i = 0; i < 7; i++)
			push_sample(16'(700 + i), 1, i == 6);
		settle();

		// negative mean truncates toward zero
		set_config(-3, 1, 205887, 0, 65535, 2, 1'b0);
		push_sample(10, 1, 0);
		push_sample(20, 1, 1);
		settle();

		// unmapped indexes must not disturb anything
		write_reg(REG_SPARE_6, '1);
		write_reg(REG_SPARE_7, '1);
		push_sample(10, 1, 0);
		push_sample(20, 1, 1);
		settle();

		// step changed in the middle of a scan, start ignored until next scan
		set_config(0, 10, 1000, 0, 65535, 2, 1'b0);
		push_sample(500, 1, 0);
		push_sample(400, 1, 0);
		settle();
		write_reg(lsnt_pkg::REG_ANGLE_STEP, pad(-20, 17, 1'b0));
		write_reg(lsnt_pkg::REG_ANGLE_START, pad(5000, 20, 1'b0));
		push_sample(300, 1, 0);
		push_sample(200, 1, 1);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			steady = (p % 4 == 3);
			if ($urandom_range(0, 4) == 0) begin
				start = longint'($urandom_range(0, 823550)) - 411775;
				step = longint'($urandom_range(0, 131071)) - 65536;
				hw = $urandom_range(0, 262143);
				lo = $urandom_range(0, 65535);
				hi = $urandom_range(0, 65535);
				need = $urandom_range(0, 8191);
				set_config(start, step, hw, lo, hi, need, 1'b1);
			end else begin
				// aim the scan so it sweeps through the sector in about 3 to 24 samples
				hw = $urandom_range(0, 205887);
				step = (2 * hw) / longint'($urandom_range(3, 24));
				if (step == 0)
					step = $urandom_range(1, 50);
				if (step > 65535)
					step = 65535;
				start = -hw - step * longint'($urandom_range(0, 2));
				if (start < -411775)
					start = -411775;
				if ($urandom_range(0, 1) == 1) begin
					step = -step;
					start = -start;
				end
				lo = $urandom_range(0, 3000);
				hi = lo + longint'($urandom_range(0, 4000));
				case ($urandom_range(0, 9))
					0: need = 0;
					1: need = $urandom_range(7, 8191);
					default: need = $urandom_range(1, 6);
				endcase
				set_config(start, step, hw, lo, hi, need, 1'b0);
			end
			items = 0;
			while (items < PHASE_ITEMS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
				for (int j = 0; j < len; j++) begin
					if ($urandom_range(0, 99) < 8) begin
						push_sample(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
						            1'($urandom_range(0, 1)));
					end else begin
						if ($urandom_range(0, 99) < 85 && cfg_floor <= cfg_ceil)
							r = 16'($urandom_range(cfg_floor, cfg_ceil));
						else
							r = 16'($urandom_range(0, 65535));
						push_sample(r, $urandom_range(0, 99) < 92, j == len - 1);
					end
				end
				items += len;
			end
			settle();
		end

		settle();
		if (mismatch_count == 0 && pending_reports.size() == 0) begin
			$display("[lidar_sector_nearest_target] OK");
		end else begin
			$display("[lidar_sector_nearest_target] ERROR");
		end
		$finish;
	end

endmodule
